>>> rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg: shared types and constants for the Muller root finder
// Micro-op encoding, datapath register names, controller/datapath structs
// and the micro-program that runs one Muller iteration.
// ----------------------------------------------------------------------------
package mrf_pkg;

  // Datapath word: 32-bit values plus headroom for the unchecked
  // intermediates (4*f2*d, -2*f2, b-D).
  localparam int WW = 36;
  typedef logic signed [WW-1:0] wide_t;

  localparam int DATA_W   = 32;
  localparam int TOL_W    = 31;
  localparam int STEP_W   = 16;
  localparam int STAT_W   = 2;
  localparam int CFG_AW   = 5;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_CONV  = 2'd0;
  localparam logic [STAT_W-1:0] ST_LIMIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FAIL  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_C4  = 3'd0;
  localparam logic [2:0] CFG_C3  = 3'd1;
  localparam logic [2:0] CFG_C2  = 3'd2;
  localparam logic [2:0] CFG_C1  = 3'd3;
  localparam logic [2:0] CFG_C0  = 3'd4;
  localparam logic [2:0] CFG_TOL = 3'd5;
  localparam logic [2:0] CFG_MAX = 3'd6;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_SQRT = 4'd4,
    OP_SEL  = 4'd5,
    OP_X4   = 4'd6,
    OP_NEG2 = 4'd7,
    OP_MOV  = 4'd8
  } op_t;

  // Register file entries
  localparam logic [3:0] R_P0 = 4'd0;
  localparam logic [3:0] R_P1 = 4'd1;
  localparam logic [3:0] R_P2 = 4'd2;
  localparam logic [3:0] R_H1 = 4'd3;
  localparam logic [3:0] R_H2 = 4'd4;
  localparam logic [3:0] R_F0 = 4'd5;
  localparam logic [3:0] R_F1 = 4'd6;
  localparam logic [3:0] R_F2 = 4'd7;
  localparam logic [3:0] R_S1 = 4'd8;
  localparam logic [3:0] R_S2 = 4'd9;
  localparam logic [3:0] R_D  = 4'd10;
  localparam logic [3:0] R_B  = 4'd11;
  localparam logic [3:0] R_T  = 4'd12;
  localparam logic [3:0] R_U  = 4'd13;
  localparam logic [3:0] R_H  = 4'd14;
  localparam logic [3:0] R_PN = 4'd15;

  // Operand sources outside the register file
  localparam logic [4:0] S_C4 = 5'd16;
  localparam logic [4:0] S_C3 = 5'd17;
  localparam logic [4:0] S_C2 = 5'd18;
  localparam logic [4:0] S_C1 = 5'd19;
  localparam logic [4:0] S_C0 = 5'd20;
  localparam logic [4:0] S_IA = 5'd21;
  localparam logic [4:0] S_IB = 5'd22;
  localparam logic [4:0] S_IC = 5'd23;

  // Program counter landmarks
  localparam logic [5:0] PC_LOAD_END = 6'd2;
  localparam logic [5:0] PC_ITER     = 6'd3;
  localparam logic [5:0] PC_LAST     = 6'd49;

  typedef struct packed {
    op_t        op;
    logic [4:0] src_a;
    logic [4:0] src_b;
    logic [3:0] dst;
    logic       chk;
  } uop_t;

  typedef struct packed {
    logic start;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic fault;
    logic conv;
  } dp_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0] c4;
    logic [DATA_W-1:0] c3;
    logic [DATA_W-1:0] c2;
    logic [DATA_W-1:0] c1;
    logic [DATA_W-1:0] c0;
    logic [TOL_W-1:0]  tol;
  } coef_t;

  typedef struct packed {
    logic              load;
    logic [STAT_W-1:0] status;
    logic [STEP_W-1:0] steps;
  } fin_t;

  function automatic logic [4:0] rs(logic [3:0] r);
    return {1'b0, r};
  endfunction

  function automatic uop_t mk(op_t op, logic [4:0] a, logic [4:0] b, logic [3:0] d,
                              logic c);
    uop_t u;
    u.op = op;
    u.src_a = a;
    u.src_b = b;
    u.dst = d;
    u.chk = c;
    return u;
  endfunction

  // Horner evaluation of the quartic at x, result into dst
  function automatic uop_t poly_op(logic [2:0] j, logic [4:0] x, logic [3:0] dst);
    uop_t u;
    case (j)
      3'd0: u = mk(OP_MUL, S_C4, x, R_T, 1'b1);
      3'd1: u = mk(OP_ADD, rs(R_T), S_C3, R_T, 1'b1);
      3'd2: u = mk(OP_MUL, rs(R_T), x, R_T, 1'b1);
      3'd3: u = mk(OP_ADD, rs(R_T), S_C2, R_T, 1'b1);
      3'd4: u = mk(OP_MUL, rs(R_T), x, R_T, 1'b1);
      3'd5: u = mk(OP_ADD, rs(R_T), S_C1, R_T, 1'b1);
      3'd6: u = mk(OP_MUL, rs(R_T), x, R_T, 1'b1);
      default: u = mk(OP_ADD, rs(R_T), S_C0, dst, 1'b1);
    endcase
    return u;
  endfunction

  // Micro-program: load (0..2), one iteration (3..46), commit (47..49)
  function automatic uop_t ucode(logic [5:0] pc);
    logic [5:0] o0;
    logic [5:0] o1;
    logic [5:0] o2;
    uop_t u;
    o0 = pc - 6'd5;
    o1 = pc - 6'd13;
    o2 = pc - 6'd21;
    if (pc >= 6'd5 && pc <= 6'd12) begin
      u = poly_op(o0[2:0], rs(R_P0), R_F0);
    end else if (pc >= 6'd13 && pc <= 6'd20) begin
      u = poly_op(o1[2:0], rs(R_P1), R_F1);
    end else if (pc >= 6'd21 && pc <= 6'd28) begin
      u = poly_op(o2[2:0], rs(R_P2), R_F2);
    end else begin
      case (pc)
        6'd0:  u = mk(OP_MOV, S_IA, S_IA, R_P0, 1'b0);
        6'd1:  u = mk(OP_MOV, S_IB, S_IB, R_P1, 1'b0);
        6'd2:  u = mk(OP_MOV, S_IC, S_IC, R_P2, 1'b0);
        6'd3:  u = mk(OP_SUB, rs(R_P1), rs(R_P0), R_H1, 1'b1);
        6'd4:  u = mk(OP_SUB, rs(R_P2), rs(R_P1), R_H2, 1'b1);
        6'd29: u = mk(OP_SUB, rs(R_F1), rs(R_F0), R_T, 1'b1);
        6'd30: u = mk(OP_DIV, rs(R_T), rs(R_H1), R_S1, 1'b1);
        6'd31: u = mk(OP_SUB, rs(R_F2), rs(R_F1), R_T, 1'b1);
        6'd32: u = mk(OP_DIV, rs(R_T), rs(R_H2), R_S2, 1'b1);
        6'd33: u = mk(OP_SUB, rs(R_S2), rs(R_S1), R_T, 1'b1);
        6'd34: u = mk(OP_ADD, rs(R_H1), rs(R_H2), R_U, 1'b1);
        6'd35: u = mk(OP_DIV, rs(R_T), rs(R_U), R_D, 1'b1);
        6'd36: u = mk(OP_MUL, rs(R_H2), rs(R_D), R_T, 1'b1);
        6'd37: u = mk(OP_ADD, rs(R_S2), rs(R_T), R_B, 1'b1);
        6'd38: u = mk(OP_MUL, rs(R_B), rs(R_B), R_T, 1'b1);
        6'd39: u = mk(OP_MUL, rs(R_F2), rs(R_D), R_U, 1'b1);
        6'd40: u = mk(OP_X4, rs(R_U), rs(R_U), R_U, 1'b0);
        6'd41: u = mk(OP_SUB, rs(R_T), rs(R_U), R_T, 1'b1);
        6'd42: u = mk(OP_SQRT, rs(R_T), rs(R_T), R_T, 1'b1);
        6'd43: u = mk(OP_SEL, rs(R_B), rs(R_T), R_U, 1'b1);
        6'd44: u = mk(OP_NEG2, rs(R_F2), rs(R_F2), R_T, 1'b0);
        6'd45: u = mk(OP_DIV, rs(R_T), rs(R_U), R_H, 1'b1);
        6'd46: u = mk(OP_ADD, rs(R_P2), rs(R_H), R_PN, 1'b1);
        6'd47: u = mk(OP_MOV, rs(R_P1), rs(R_P1), R_P0, 1'b0);
        6'd48: u = mk(OP_MOV, rs(R_P2), rs(R_P2), R_P1, 1'b0);
        default: u = mk(OP_MOV, rs(R_PN), rs(R_PN), R_P2, 1'b0);
      endcase
    end
    return u;
  endfunction

endpackage

>>> rtl/mrf_in_if.sv
// ----------------------------------------------------------------------------
// mrf_in_if: start point channel
// Valid/ready channel carrying three starting points.
// ----------------------------------------------------------------------------
interface mrf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_a;
  logic [31:0] start_b;
  logic [31:0] start_c;

  modport source (output valid, output start_a, output start_b, output start_c,
                  input ready);
  modport sink (input valid, input start_a, input start_b, input start_c,
                output ready);
endinterface

>>> rtl/mrf_out_if.sv
// ----------------------------------------------------------------------------
// mrf_out_if: result channel
// Valid/ready channel carrying root, status and step count.
// ----------------------------------------------------------------------------
interface mrf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] root;
  logic [1:0]  status;
  logic [15:0] steps_taken;

  modport source (output valid, output root, output status, output steps_taken,
                  input ready);
  modport sink (input valid, input root, input status, input steps_taken,
                output ready);
endinterface

>>> rtl/mrf_regs.sv
// ----------------------------------------------------------------------------
// mrf_regs: configuration registers
// APB-style register bank for the coefficients, tolerance and step limit.
// ----------------------------------------------------------------------------
module mrf_regs #(
  parameter logic [31:0] RST_C4  = 32'h0100_0000,
  parameter logic [31:0] RST_C3  = 32'hFD00_0000,
  parameter logic [31:0] RST_ONE = 32'h0100_0000,
  parameter logic [30:0] RST_TOL = 31'd17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrf_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output mrf_pkg::coef_t                coef,
  output logic [mrf_pkg::STEP_W-1:0]    max_steps
);
  import mrf_pkg::*;

  coef_t             coef_r;
  logic [STEP_W-1:0] max_r;
  logic [2:0]        idx;
  logic              wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write on the access phase of a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.c4  <= RST_C4;
      coef_r.c3  <= RST_C3;
      coef_r.c2  <= RST_ONE;
      coef_r.c1  <= RST_ONE;
      coef_r.c0  <= RST_ONE;
      coef_r.tol <= RST_TOL;
      max_r      <= 16'd9997;
    end else if (wr) begin
      case (idx)
        CFG_C4:  coef_r.c4  <= pwdata;
        CFG_C3:  coef_r.c3  <= pwdata;
        CFG_C2:  coef_r.c2  <= pwdata;
        CFG_C1:  coef_r.c1  <= pwdata;
        CFG_C0:  coef_r.c0  <= pwdata;
        CFG_TOL: coef_r.tol <= pwdata[TOL_W-1:0];
        CFG_MAX: max_r      <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      CFG_C4:  prdata = coef_r.c4;
      CFG_C3:  prdata = coef_r.c3;
      CFG_C2:  prdata = coef_r.c2;
      CFG_C1:  prdata = coef_r.c1;
      CFG_C0:  prdata = coef_r.c0;
      CFG_TOL: prdata = {1'b0, coef_r.tol};
      CFG_MAX: prdata = {16'd0, max_r};
      default: prdata = '0;
    endcase
  end

  assign coef      = coef_r;
  assign max_steps = max_r;
endmodule

>>> rtl/mrf_dp.sv
// ----------------------------------------------------------------------------
// mrf_dp: arithmetic datapath
// Register file, adder, multiplier, radix-2 divider and bit-pair square root
// executing one micro-op at a time for the controller.
// ----------------------------------------------------------------------------
module mrf_dp #(
  parameter int FRAC_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mrf_pkg::dp_cmd_t           cmd,
  output mrf_pkg::dp_stat_t          stat,
  input  logic                       ld,
  input  logic [31:0]                start_a,
  input  logic [31:0]                start_b,
  input  logic [31:0]                start_c,
  input  mrf_pkg::coef_t             coef,
  output logic [31:0]                root
);
  import mrf_pkg::*;

  typedef enum logic [8:0] {
    DP_IDLE  = 9'b000000001,
    DP_READ  = 9'b000000010,
    DP_DISP  = 9'b000000100,
    DP_MULW  = 9'b000001000,
    DP_DIV   = 9'b000010000,
    DP_DIVW  = 9'b000100000,
    DP_SQRT  = 9'b001000000,
    DP_SQRTW = 9'b010000000,
    DP_WB    = 9'b100000000
  } dp_state_t;

  dp_state_t          state_r, state_nxt;
  wide_t              mem [16];
  uop_t               uop_r;
  wide_t              opa_r, opb_r, res_r;
  logic               flt_r;
  logic [31:0]        ia_r, ib_r, ic_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] mshift;
  logic [63:0]        quo_r;
  logic [32:0]        rem_r;
  logic [32:0]        dvs_r;
  logic               neg_r;
  logic [63:0]        x_r, r_r, bit_r;
  logic [5:0]         cnt_r;
  logic               conv_r;
  logic [31:0]        root_r;
  wide_t              alu;
  wide_t              ep, em, aep, aem;
  wide_t              mag_a, mag_b;
  logic [33:0]        rsh;
  logic [63:0]        sq_t;
  logic               wb_fault;
  wide_t              habs;
  logic [31:0]        qlo;
  logic               qflt;

  function automatic wide_t pick(logic [4:0] s, coef_t c, logic [31:0] a,
                                 logic [31:0] b, logic [31:0] d);
    wide_t v;
    case (s)
      S_C4:    v = wide_t'(signed'(c.c4));
      S_C3:    v = wide_t'(signed'(c.c3));
      S_C2:    v = wide_t'(signed'(c.c2));
      S_C1:    v = wide_t'(signed'(c.c1));
      S_C0:    v = wide_t'(signed'(c.c0));
      S_IA:    v = wide_t'(signed'(a));
      S_IB:    v = wide_t'(signed'(b));
      S_IC:    v = wide_t'(signed'(d));
      default: v = '0;
    endcase
    return v;
  endfunction

  // Combinational ALU and helpers
  always_comb begin
    ep    = opa_r + opb_r;
    em    = opa_r - opb_r;
    aep   = ep[WW-1] ? -ep : ep;
    aem   = em[WW-1] ? -em : em;
    mag_a = opa_r[WW-1] ? -opa_r : opa_r;
    mag_b = opb_r[WW-1] ? -opb_r : opb_r;
    case (uop_r.op)
      OP_ADD:  alu = ep;
      OP_SUB:  alu = em;
      OP_X4:   alu = opa_r <<< 2;
      OP_NEG2: alu = -(opa_r <<< 1);
      OP_SEL:  alu = ($unsigned(aep) >= $unsigned(aem)) ? ep : em;
      default: alu = opa_r;
    endcase
    mshift = prod_r >>> FRAC_BITS;
    rsh    = {rem_r, quo_r[63]};
    sq_t   = r_r + bit_r;
    qlo    = quo_r[31:0];
    qflt   = (quo_r[63:32] != '0) || (neg_r ? (qlo > 32'h8000_0000) : qlo[31]);
    wb_fault = flt_r || (uop_r.chk && !((res_r[WW-1:31] == '0) || (&res_r[WW-1:31])));
    habs   = res_r[WW-1] ? -res_r : res_r;
  end

  // Sequence one micro-op
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DP_IDLE:  if (cmd.start) state_nxt = DP_READ;
      DP_READ:  state_nxt = DP_DISP;
      DP_DISP: begin
        case (uop_r.op)
          OP_MUL:  state_nxt = DP_MULW;
          OP_DIV:  state_nxt = (opb_r == '0) ? DP_WB : DP_DIV;
          OP_SQRT: state_nxt = opa_r[WW-1] ? DP_WB : DP_SQRT;
          default: state_nxt = DP_WB;
        endcase
      end
      DP_MULW:  state_nxt = DP_WB;
      DP_DIV:   if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = DP_DIVW;
      DP_DIVW:  state_nxt = DP_WB;
      DP_SQRT:  if (cnt_r == 6'(SQRT_STEPS - 1)) state_nxt = DP_SQRTW;
      DP_SQRTW: state_nxt = DP_WB;
      DP_WB:    state_nxt = DP_IDLE;
      default:  state_nxt = DP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Operand fetch, execution units and write-back
  always_ff @(posedge clk) begin
    if (ld) begin
      ia_r <= start_a;
      ib_r <= start_b;
      ic_r <= start_c;
    end
    case (state_r)
      DP_IDLE: if (cmd.start) uop_r <= cmd.uop;
      DP_READ: begin
        opa_r <= uop_r.src_a[4] ? pick(uop_r.src_a, coef, ia_r, ib_r, ic_r)
                                : mem[uop_r.src_a[3:0]];
        opb_r <= uop_r.src_b[4] ? pick(uop_r.src_b, coef, ia_r, ib_r, ic_r)
                                : mem[uop_r.src_b[3:0]];
      end
      DP_DISP: begin
        res_r  <= alu;
        flt_r  <= 1'b0;
        prod_r <= signed'(opa_r[31:0]) * signed'(opb_r[31:0]);
        cnt_r  <= '0;
        if (uop_r.op == OP_DIV) begin
          flt_r <= (opb_r == '0);
          quo_r <= 64'(mag_a) << FRAC_BITS;
          rem_r <= '0;
          dvs_r <= mag_b[32:0];
          neg_r <= opa_r[WW-1] ^ opb_r[WW-1];
        end
        if (uop_r.op == OP_SQRT) begin
          flt_r <= opa_r[WW-1];
          x_r   <= 64'(opa_r[31:0]) << FRAC_BITS;
          r_r   <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      DP_MULW: begin
        res_r <= mshift[WW-1:0];
        flt_r <= !((mshift[63:31] == '0) || (&mshift[63:31]));
      end
      DP_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        if (rsh >= {1'b0, dvs_r}) begin
          rem_r <= 33'(rsh - {1'b0, dvs_r});
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= rsh[32:0];
          quo_r <= {quo_r[62:0], 1'b0};
        end
      end
      DP_DIVW: begin
        res_r <= neg_r ? -wide_t'({4'd0, qlo}) : wide_t'({4'd0, qlo});
        flt_r <= qflt;
      end
      DP_SQRT: begin
        cnt_r <= cnt_r + 6'd1;
        bit_r <= bit_r >> 2;
        if (x_r >= sq_t) begin
          x_r <= x_r - sq_t;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
      end
      DP_SQRTW: begin
        res_r <= r_r[WW-1:0];
        flt_r <= (r_r[63:WW-1] != '0);
      end
      DP_WB: begin
        if (!wb_fault) begin
          mem[uop_r.dst] <= res_r;
          if (uop_r.dst == R_P2) root_r <= res_r[31:0];
          if (uop_r.dst == R_H) conv_r <= ($unsigned(habs) < {5'd0, coef.tol});
        end
      end
      default: ;
    endcase
  end

  assign stat.done  = (state_r == DP_WB);
  assign stat.fault = wb_fault;
  assign stat.conv  = conv_r;
  assign root       = root_r;
endmodule

>>> rtl/mrf_ctrl.sv
// ----------------------------------------------------------------------------
// mrf_ctrl: iteration controller
// Steps the micro-program, counts iterations and decides the end of a run.
// ----------------------------------------------------------------------------
module mrf_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          ld,
  input  logic [mrf_pkg::STEP_W-1:0]    max_steps,
  output mrf_pkg::dp_cmd_t              cmd,
  input  mrf_pkg::dp_stat_t             stat,
  input  logic                          slot_free,
  output mrf_pkg::fin_t                 fin
);
  import mrf_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_ISSUE = 4'b0010,
    C_WAIT  = 4'b0100,
    C_FIN   = 4'b1000
  } ctrl_state_t;

  ctrl_state_t       state_r, state_nxt;
  logic [5:0]        pc_r, pc_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  // Next-state and command decode
  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    steps_nxt  = steps_r;
    status_nxt = status_r;
    in_ready   = 1'b0;
    ld         = 1'b0;
    cmd.start  = 1'b0;
    cmd.uop    = ucode(pc_r);
    fin.load   = 1'b0;
    fin.status = status_r;
    fin.steps  = steps_r;
    case (state_r)
      C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ld        = 1'b1;
          pc_nxt    = '0;
          steps_nxt = '0;
          state_nxt = C_ISSUE;
        end
      end
      C_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = C_WAIT;
      end
      C_WAIT: begin
        if (stat.done) begin
          if (stat.fault) begin
            status_nxt = ST_FAIL;
            state_nxt  = C_FIN;
          end else if (pc_r == PC_LOAD_END || pc_r == PC_LAST) begin
            if (pc_r == PC_LAST && stat.conv) begin
              status_nxt = ST_CONV;
              state_nxt  = C_FIN;
            end else if (steps_r == max_steps) begin
              status_nxt = ST_LIMIT;
              state_nxt  = C_FIN;
            end else begin
              steps_nxt = steps_r + 16'd1;
              pc_nxt    = PC_ITER;
              state_nxt = C_ISSUE;
            end
          end else begin
            pc_nxt    = pc_r + 6'd1;
            state_nxt = C_ISSUE;
          end
        end
      end
      C_FIN: begin
        // hold until the output register frees up
        fin.load = slot_free;
        if (slot_free) state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= C_IDLE;
      pc_r     <= '0;
      steps_r  <= '0;
      status_r <= ST_LIMIT;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      steps_r  <= steps_nxt;
      status_r <= status_nxt;
    end
  end
endmodule

>>> rtl/muller_root_finder_top.sv
// Each iteration is 47 micro-ops on one shared datapath, dominated by four
//   divides and a square root. Throughput: one start triple per run.
// A new triple is taken while the previous result waits in the output register.
// Reset (rst_n low, synchronous) returns the controller to idle, empties the
// output register and restores the default coefficients, tolerance and limit.
// ----------------------------------------------------------------------------
// muller_root_finder_top: Muller's method root finder for a quartic
// Configuration bank, iteration controller, datapath and output register.
// ----------------------------------------------------------------------------
module muller_root_finder_top #(
  parameter int FRAC_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mrf_in_if.sink                     in_ch,
  mrf_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mrf_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mrf_pkg::*;

  localparam longint ONE   = 64'sd1 <<< FRAC_BITS;
  localparam longint M3    = -3 * ONE;
  localparam longint IMAX  = 64'sd2147483647;
  localparam longint IMIN  = -64'sd2147483648;
  localparam longint C1V   = (ONE > IMAX) ? IMAX : ONE;
  localparam longint C3V   = (M3 < IMIN) ? IMIN : M3;
  localparam longint TOLV  = (ONE + 64'sd500000) / 64'sd1000000;

  coef_t             coef;
  logic [STEP_W-1:0] max_steps;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  fin_t              fin;
  logic              ld;
  logic              slot_free;
  logic [31:0]       root;
  logic              out_valid_r;
  logic [31:0]       root_r;
  logic [STAT_W-1:0] status_r;
  logic [STEP_W-1:0] steps_r;

  mrf_regs #(
    .RST_C4  (32'(C1V)),
    .RST_C3  (32'(C3V)),
    .RST_ONE (32'(C1V)),
    .RST_TOL (31'(TOLV))
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .coef      (coef),
    .max_steps (max_steps)
  );

  mrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .ld        (ld),
    .max_steps (max_steps),
    .cmd       (cmd),
    .stat      (stat),
    .slot_free (slot_free),
    .fin       (fin)
  );

  mrf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .ld      (ld),
    .start_a (in_ch.start_a),
    .start_b (in_ch.start_b),
    .start_c (in_ch.start_c),
    .coef    (coef),
    .root    (root)
  );

  assign slot_free = !out_valid_r || out_ch.ready;

  // Output register: load on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.load) begin
      root_r   <= root;
      status_r <= fin.status;
      steps_r  <= fin.steps;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.root        = root_r;
  assign out_ch.status      = status_r;
  assign out_ch.steps_taken = steps_r;
endmodule
